@@ src/sbda_pkg.sv @@
package sbda_pkg;

   localparam int VALUE_WIDTH        = 64;
   localparam int TEXT_WIDTH         = 6;
   localparam int DEFAULT_VALUE_BITS = 64;
   localparam int BITS_PER_STEP      = 4;
   localparam int DIGIT_WIDTH        = 4;

   localparam logic [TEXT_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [TEXT_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [TEXT_WIDTH-1:0] CHAR_NINE  = 6'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift_bits;
      logic shift_digit;
      logic out_sign;
      logic out_digit;
   } cmd_type;

   typedef struct packed {
      logic negative;
      logic bits_last;
      logic digits_last;
      logic top_zero;
      logic out_free;
   } status_type;

endpackage

@@ src/sbda_ctrl.sv @@
module sbda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sbda_pkg::status_type status,
   output sbda_pkg::cmd_type    cmd
);
   import sbda_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift_bits = 1'b1;
            if (status.bits_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.top_zero && !status.digits_last) begin
               cmd.shift_digit = 1'b1;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_digit   = 1'b1;
               cmd.shift_digit = 1'b1;
               if (status.digits_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // work only leaves idle through an accepted word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in != ST_IDLE) |-> (req_valid && cmd.load))
      else $error("left idle without a word");

   // digits are only emitted once conversion and skipping are done
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_digit |-> $past(state_ff == ST_SKIP || state_ff == ST_SIGN
                              || state_ff == ST_EMIT))
      else $error("digit emitted before conversion finished");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> $past(status.negative))
      else $error("sign state on a non-negative value");

endmodule

@@ src/sbda_dp.sv @@
module sbda_dp #(
   parameter int VALUE_BITS = sbda_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic signed [sbda_pkg::VALUE_WIDTH-1:0]     req_value,
   input  sbda_pkg::cmd_type                           cmd,
   output sbda_pkg::status_type                        status,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic        [sbda_pkg::TEXT_WIDTH-1:0]      rsp_text_char,
   output logic                                        rsp_last_char
);
   import sbda_pkg::*;

   localparam int ITERS      = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int SHIFT_BITS = ITERS * BITS_PER_STEP;
   localparam int DIGITS     = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS   = DIGITS * DIGIT_WIDTH;
   localparam int BCNT_W     = $clog2(ITERS + 1);
   localparam int DCNT_W     = $clog2(DIGITS + 1);

   logic [VALUE_BITS-1:0]  raw;
   logic [VALUE_BITS-1:0]  mag_abs;
   logic                   neg_in;
   logic [SHIFT_BITS-1:0]  mag_ff, mag_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]    bcd_step;
   logic [SHIFT_BITS-1:0]  mag_step;
   logic                   neg_ff;
   logic [BCNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0]      digit_cnt_ff, digit_cnt_in;
   logic [DIGIT_WIDTH-1:0] top_digit;
   logic                   out_valid_ff, out_valid_in;
   logic [TEXT_WIDTH-1:0]  out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   assign raw       = req_value[VALUE_BITS-1:0];
   assign neg_in    = raw[VALUE_BITS-1];
   assign mag_abs   = neg_in ? VALUE_BITS'(~raw + 1'b1) : raw;
   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_WIDTH];

   // shift-and-add-3 over one group of bits
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_step[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5) begin
               bcd_step[d*DIGIT_WIDTH +: DIGIT_WIDTH] =
                  bcd_step[d*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_BITS-2:0], mag_step[SHIFT_BITS-1]};
         mag_step = {mag_step[SHIFT_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      if (cmd.load) begin
         mag_in       = SHIFT_BITS'(mag_abs);
         bcd_in       = '0;
         bit_cnt_in   = BCNT_W'(ITERS);
         digit_cnt_in = DCNT_W'(DIGITS);
      end else if (cmd.shift_bits) begin
         mag_in     = mag_step;
         bcd_in     = bcd_step;
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.shift_digit) begin
         bcd_in       = {bcd_ff[BCD_BITS-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
         digit_cnt_in = digit_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_MINUS;
         out_last_in  = 1'b0;
      end else if (cmd.out_digit) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_ZERO + TEXT_WIDTH'(top_digit);
         out_last_in  = (digit_cnt_ff == DCNT_W'(1));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      if (cmd.load) begin
         neg_ff <= neg_in;
      end
   end

   assign status.negative    = neg_ff;
   assign status.bits_last   = (bit_cnt_ff == BCNT_W'(1));
   assign status.digits_last = (digit_cnt_ff == DCNT_W'(1));
   assign status.top_zero    = (top_digit == '0);
   assign status.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == CHAR_MINUS
                     || (rsp_text_char >= CHAR_ZERO && rsp_text_char <= CHAR_NINE)))
      else $error("character out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_char == CHAR_MINUS) |-> !rsp_last_char)
      else $error("minus sign flagged as last");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sign || cmd.out_digit) |-> status.out_free)
      else $error("output register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_digit |-> (top_digit <= 4'd9))
      else $error("digit above nine");

endmodule

@@ src/signed_binary_to_decimal_ascii_core.sv @@
// channel   ports                                     direction
// req       req_valid, req_ready, req_value           in
// rsp       rsp_valid, rsp_ready, rsp_text_char,      out
//           rsp_last_char
//
// a word is converted by shift-and-add-3 in groups of four bits, then its leading zero
// digits are skipped, then a minus sign is sent for a negative value and then one
// character per remaining digit.
// the next word is taken in the cycle after the last character enters the output
// register.
// reset clears the controller state and the output valid flag.
// a stalled rsp channel holds the output register and pauses character emission.
module signed_binary_to_decimal_ascii_core #(
   parameter int VALUE_BITS = sbda_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sbda_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic        [sbda_pkg::TEXT_WIDTH-1:0]  rsp_text_char,
   output logic                                    rsp_last_char
);
   import sbda_pkg::*;

   cmd_type    cmd;
   status_type status;

   sbda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbda_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
